[rtl/core/vsn_pkg.sv]
// ---------------------------------------------------------------------------
// vsn_pkg: shared constants for the voxel Sobel normal block
// Widths, defaults and register indexes used by the interfaces and modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vsn_pkg;

    localparam int MAX_DIM_DEF   = 64;
    localparam int DIST_BITS_DEF = 16;

    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int NORM_W    = 16;
    localparam int COORD_W   = 6;

    // normalizer datapath
    localparam int MAG_BITS    = 21;
    localparam int SQ_BITS     = 2 * MAG_BITS;
    localparam int N_BITS      = SQ_BITS + 2;
    localparam int Q_BITS      = 32;
    localparam int ROOT_BITS   = 16;
    localparam int SREM_BITS   = 19;
    localparam int DIV_STEPS   = 31;
    localparam int SQRT_STEPS  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2,
        REG_NONE   = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

[rtl/core/vsn_if.sv]
// ---------------------------------------------------------------------------
// vsn_if: channel interfaces
// Voxel input, normal output and configuration write channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vsn_voxel_if #(parameter int DIST_BITS = vsn_pkg::DIST_BITS_DEF);
    logic                        valid;
    logic                        ready;
    logic signed [DIST_BITS-1:0] dist_value;
    logic                        surface_flag;
    modport source (output valid, dist_value, surface_flag, input ready);
    modport sink   (input valid, dist_value, surface_flag, output ready);
endinterface

interface vsn_normal_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vsn_pkg::NORM_W-1:0]    normal_x;
    logic signed [vsn_pkg::NORM_W-1:0]    normal_y;
    logic signed [vsn_pkg::NORM_W-1:0]    normal_z;
    logic                                 is_surface;
    logic        [vsn_pkg::COORD_W-1:0]   voxel_x;
    logic        [vsn_pkg::COORD_W-1:0]   voxel_y;
    logic        [vsn_pkg::COORD_W-1:0]   voxel_z;
    logic                                 last_of_volume;
    modport source (output valid, normal_x, normal_y, normal_z, is_surface,
                    voxel_x, voxel_y, voxel_z, last_of_volume, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, is_surface,
                    voxel_x, voxel_y, voxel_z, last_of_volume, output ready);
endinterface

interface vsn_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [vsn_pkg::CFG_IDX_W-1:0]    addr;
    logic [vsn_pkg::SIZE_W-1:0]       data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

[rtl/core/voxel_sobel_normal.sv]
// ---------------------------------------------------------------------------
// voxel_sobel_normal: streaming 3D Sobel surface normal
// Stores the last three x planes in one memory, reads the 3x3x3 window of
// each interior voxel and normalizes its Sobel gradient to Q1.14 when the centre is a surface voxel.
// ---------------------------------------------------------------------------
//  channel      dir   handshake      payload
//  voxel_in     in    valid/ready    dist_value, surface_flag
//  normal_out   out   valid/ready    normal_x/y/z, is_surface, voxel_x/y/z,
//                                    last_of_volume
//  cfg          in    valid/ready    addr, data (size_x, size_y, size_z)
//
//  A voxel without a result only writes the plane memory.
//  An interior voxel makes 27 window reads through the single memory port;
//  surface voxels add the normalizer, which halves the gradient until it
//  fits, then squares, divides and takes square roots per component.
//  Reset gives 64^3 sizes and position (0,0,0); a size register write restarts.
//  A pending result is held in the output register while the next voxel
//  is taken; a new result waits for that register to empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voxel_sobel_normal
    import vsn_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    vsn_voxel_if.sink   voxel_in,
    vsn_normal_if.source normal_out,
    vsn_cfg_if.sink     cfg
);

    localparam int DIST_BITS = DIST_BITS_DEF;
    localparam int PW        = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * PW + 2;
    localparam int MEM_DEPTH = 3 * (2 ** (2 * PW));
    localparam int WORD_W    = DIST_BITS + 1;
    localparam int GW        = (DIST_BITS + 6 > MAG_BITS + 1) ? DIST_BITS + 6 : MAG_BITS + 1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b00_0001,
        ST_READ   = 6'b00_0010,
        ST_DRAIN  = 6'b00_0100,
        ST_DECIDE = 6'b00_1000,
        ST_NORM   = 6'b01_0000,
        ST_FIN    = 6'b10_0000
    } state_t;

    function automatic logic [PW-1:0] lim_of(input logic [SIZE_W-1:0] s);
        int v;
        begin
            v = int'(s);
            if (v < 3)
                v = 3;
            if (v > MAX_DIM)
                v = MAX_DIM;
            return PW'(v - 1);
        end
    endfunction

    function automatic logic [1:0] plane_of(input logic [1:0] p, input logic [1:0] off);
        logic [1:0] r;
        begin
            case (off)
                2'd2:    r = p;
                2'd1:    r = (p == 2'd0) ? 2'd2 : p - 2'd1;
                default: r = (p == 2'd2) ? 2'd0 : p + 2'd1;
            endcase
            return r;
        end
    endfunction

    logic [WORD_W-1:0] mem [MEM_DEPTH];

    state_t               state_reg;
    logic [SIZE_W-1:0]    size_x_reg, size_y_reg, size_z_reg;
    logic [PW-1:0]        pos_x_reg, pos_y_reg, pos_z_reg;
    logic [1:0]           px3_reg;
    logic [1:0]           cp_reg;
    logic [PW-1:0]        y0_reg, z0_reg;
    logic [PW-1:0]        cx_reg, cy_reg, cz_reg;
    logic                 last_reg;
    logic [1:0]           ri_reg, rj_reg, rk_reg;
    logic                 dv_reg;
    logic [1:0]           di_reg, dj_reg, dk_reg;
    logic [WORD_W-1:0]    rdata_reg;
    logic signed [GW-1:0] sx_reg, sy_reg, sz_reg;
    logic                 csurf_reg;
    logic                 norm_start_reg;

    logic                       out_valid_reg;
    logic signed [NORM_W-1:0]   onx_reg, ony_reg, onz_reg;
    logic                       osurf_reg, olast_reg;
    logic [COORD_W-1:0]         ox_reg, oy_reg, oz_reg;

    logic                 in_acc, cfg_acc, emit, vol_last;
    logic [PW-1:0]        lim_x, lim_y, lim_z;
    logic [ADDR_W-1:0]    waddr, raddr, addr;
    logic signed [GW-1:0] dext;
    logic [1:0]           shx, shy, shz;
    logic signed [GW-1:0] tx, ty, tz;
    logic                 norm_done;
    logic signed [NORM_W-1:0] nx, ny, nz;
    logic                 out_free;

    assign voxel_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign in_acc         = voxel_in.valid && voxel_in.ready;
    assign cfg_acc        = cfg.valid;
    assign out_free       = !out_valid_reg || normal_out.ready;

    always_comb
    begin
        lim_x    = lim_of(size_x_reg);
        lim_y    = lim_of(size_y_reg);
        lim_z    = lim_of(size_z_reg);
        vol_last = (pos_x_reg == lim_x) && (pos_y_reg == lim_y) && (pos_z_reg == lim_z);
        emit     = (pos_x_reg >= PW'(2)) && (pos_y_reg >= PW'(2)) && (pos_z_reg >= PW'(2));
        waddr    = {px3_reg, pos_y_reg, pos_z_reg};
        raddr    = {plane_of(cp_reg, ri_reg), y0_reg + PW'(rj_reg), z0_reg + PW'(rk_reg)};
        addr     = in_acc ? waddr : raddr;
    end

    // window taps: weight 4 at the center tap, 2 on edges, 1 at corners
    always_comb
    begin
        dext = GW'(signed'(rdata_reg[DIST_BITS-1:0]));
        shx  = 2'(dj_reg == 2'd1) + 2'(dk_reg == 2'd1);
        shy  = 2'(di_reg == 2'd1) + 2'(dk_reg == 2'd1);
        shz  = 2'(di_reg == 2'd1) + 2'(dj_reg == 2'd1);
        tx   = dext <<< shx;
        ty   = dext <<< shy;
        tz   = dext <<< shz;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            mem[addr] <= {voxel_in.surface_flag, voxel_in.dist_value};
        rdata_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            size_x_reg     <= SIZE_W'(64);
            size_y_reg     <= SIZE_W'(64);
            size_z_reg     <= SIZE_W'(64);
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            pos_z_reg      <= '0;
            px3_reg        <= 2'd0;
            dv_reg         <= 1'b0;
            norm_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            ri_reg         <= 2'd0;
            rj_reg         <= 2'd0;
            rk_reg         <= 2'd0;
        end
        else
        begin
            norm_start_reg <= 1'b0;
            dv_reg         <= 1'b0;
            if (normal_out.ready)
                out_valid_reg <= 1'b0;

            if (cfg_acc)
            begin
                unique case (cfg_reg_t'(cfg.addr))
                    REG_SIZE_X: size_x_reg <= cfg.data;
                    REG_SIZE_Y: size_y_reg <= cfg.data;
                    REG_SIZE_Z: size_z_reg <= cfg.data;
                    default: ;
                endcase
                if (cfg_reg_t'(cfg.addr) != REG_NONE)
                begin
                    pos_x_reg <= '0;
                    pos_y_reg <= '0;
                    pos_z_reg <= '0;
                    px3_reg   <= 2'd0;
                end
            end
            else if (in_acc)
            begin
                if (vol_last)
                begin
                    pos_x_reg <= '0;
                    pos_y_reg <= '0;
                    pos_z_reg <= '0;
                    px3_reg   <= 2'd0;
                end
                else if (pos_z_reg != lim_z)
                    pos_z_reg <= pos_z_reg + PW'(1);
                else
                begin
                    pos_z_reg <= '0;
                    if (pos_y_reg != lim_y)
                        pos_y_reg <= pos_y_reg + PW'(1);
                    else
                    begin
                        pos_y_reg <= '0;
                        pos_x_reg <= pos_x_reg + PW'(1);
                        px3_reg   <= (px3_reg == 2'd2) ? 2'd0 : px3_reg + 2'd1;
                    end
                end
            end

            if (dv_reg)
            begin
                sx_reg <= (di_reg == 2'd2) ? sx_reg + tx : (di_reg == 2'd0) ? sx_reg - tx : sx_reg;
                sy_reg <= (dj_reg == 2'd2) ? sy_reg + ty : (dj_reg == 2'd0) ? sy_reg - ty : sy_reg;
                sz_reg <= (dk_reg == 2'd2) ? sz_reg + tz : (dk_reg == 2'd0) ? sz_reg - tz : sz_reg;
                if (di_reg == 2'd1 && dj_reg == 2'd1 && dk_reg == 2'd1)
                    csurf_reg <= rdata_reg[DIST_BITS];
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && emit)
                    begin
                        cp_reg    <= px3_reg;
                        y0_reg    <= pos_y_reg - PW'(2);
                        z0_reg    <= pos_z_reg - PW'(2);
                        cx_reg    <= pos_x_reg - PW'(1);
                        cy_reg    <= pos_y_reg - PW'(1);
                        cz_reg    <= pos_z_reg - PW'(1);
                        last_reg  <= vol_last;
                        sx_reg    <= '0;
                        sy_reg    <= '0;
                        sz_reg    <= '0;
                        ri_reg    <= 2'd0;
                        rj_reg    <= 2'd0;
                        rk_reg    <= 2'd0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    dv_reg <= 1'b1;
                    di_reg <= ri_reg;
                    dj_reg <= rj_reg;
                    dk_reg <= rk_reg;
                    if (rk_reg != 2'd2)
                        rk_reg <= rk_reg + 2'd1;
                    else
                    begin
                        rk_reg <= 2'd0;
                        if (rj_reg != 2'd2)
                            rj_reg <= rj_reg + 2'd1;
                        else
                        begin
                            rj_reg <= 2'd0;
                            if (ri_reg != 2'd2)
                                ri_reg <= ri_reg + 2'd1;
                            else
                            begin
                                ri_reg    <= 2'd0;
                                state_reg <= ST_DRAIN;
                            end
                        end
                    end
                end
                ST_DRAIN:
                    state_reg <= ST_DECIDE;
                ST_DECIDE:
                begin
                    if (csurf_reg)
                    begin
                        norm_start_reg <= 1'b1;
                        state_reg      <= ST_NORM;
                    end
                    else
                        state_reg <= ST_FIN;
                end
                ST_NORM:
                begin
                    if (norm_done)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && out_free)
        begin
            onx_reg   <= csurf_reg ? nx : '0;
            ony_reg   <= csurf_reg ? ny : '0;
            onz_reg   <= csurf_reg ? nz : '0;
            osurf_reg <= csurf_reg;
            ox_reg    <= COORD_W'(cx_reg);
            oy_reg    <= COORD_W'(cy_reg);
            oz_reg    <= COORD_W'(cz_reg);
            olast_reg <= last_reg;
        end
    end

    vsn_norm #(
        .GW (GW)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start_reg),
        .sum_x (sx_reg),
        .sum_y (sy_reg),
        .sum_z (sz_reg),
        .done  (norm_done),
        .nx    (nx),
        .ny    (ny),
        .nz    (nz)
    );

    assign normal_out.valid          = out_valid_reg;
    assign normal_out.normal_x       = onx_reg;
    assign normal_out.normal_y       = ony_reg;
    assign normal_out.normal_z       = onz_reg;
    assign normal_out.is_surface     = osurf_reg;
    assign normal_out.voxel_x        = ox_reg;
    assign normal_out.voxel_y        = oy_reg;
    assign normal_out.voxel_z        = oz_reg;
    assign normal_out.last_of_volume = olast_reg;

endmodule

`default_nettype wire

[rtl/core/vsn_norm.sv]
// ---------------------------------------------------------------------------
// vsn_norm: gradient normalizer
// Scales a gradient to a Q1.14 unit vector with a shared restoring divider
// and a digit-by-digit square root, one component at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vsn_norm
    import vsn_pkg::*;
#(
    parameter int GW = 22
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [GW-1:0]     sum_x,
    input  wire logic signed [GW-1:0]     sum_y,
    input  wire logic signed [GW-1:0]     sum_z,
    output logic                          done,
    output logic signed [NORM_W-1:0]      nx,
    output logic signed [NORM_W-1:0]      ny,
    output logic signed [NORM_W-1:0]      nz
);

    typedef enum logic [7:0] {
        N_IDLE  = 8'b0000_0001,
        N_SHIFT = 8'b0000_0010,
        N_SQ    = 8'b0000_0100,
        N_SUM   = 8'b0000_1000,
        N_DINIT = 8'b0001_0000,
        N_DIV   = 8'b0010_0000,
        N_SQRT  = 8'b0100_0000,
        N_STORE = 8'b1000_0000
    } nstate_t;

    nstate_t                  state_reg;
    logic [GW-1:0]            mag_reg [3];
    logic [2:0]               neg_reg;
    logic [SQ_BITS-1:0]       sq_reg [3];
    logic [N_BITS-1:0]        n_reg;
    logic [1:0]               comp_reg;
    logic [4:0]               cnt_reg;
    logic [N_BITS-1:0]        rem_reg;
    logic [Q_BITS-1:0]        q_reg;
    logic [SREM_BITS-1:0]     srem_reg;
    logic [ROOT_BITS-1:0]     root_reg;
    logic signed [NORM_W-1:0] res_reg [3];
    logic                     done_reg;

    logic                     big;
    logic [MAG_BITS-1:0]      mag_lo;
    logic [N_BITS-1:0]        n_sum;
    logic                     bit_in;
    logic [N_BITS:0]          dtrial;
    logic [SREM_BITS-1:0]     stmp;
    logic [SREM_BITS-1:0]     strial;
    logic [ROOT_BITS:0]       rnd;
    logic [NORM_W-1:0]        rmag;

    always_comb
    begin
        big    = (|mag_reg[0][GW-1:MAG_BITS]) || (|mag_reg[1][GW-1:MAG_BITS])
                 || (|mag_reg[2][GW-1:MAG_BITS]);
        mag_lo = mag_reg[comp_reg][MAG_BITS-1:0];
        n_sum  = N_BITS'(sq_reg[0]) + N_BITS'(sq_reg[1]) + N_BITS'(sq_reg[2]);
        bit_in = (cnt_reg == 5'(DIV_STEPS - 1)) ? sq_reg[comp_reg][0] : 1'b0;
        dtrial = {rem_reg, bit_in};
        stmp   = {srem_reg[SREM_BITS-3:0], q_reg[Q_BITS-1:Q_BITS-2]};
        strial = SREM_BITS'({root_reg, 2'b01});
        rnd    = (ROOT_BITS+1)'(root_reg) + (ROOT_BITS+1)'(1);
        rmag   = NORM_W'(rnd[ROOT_BITS:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            comp_reg  <= 2'd0;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        mag_reg[0] <= sum_x[GW-1] ? GW'(-sum_x) : GW'(sum_x);
                        mag_reg[1] <= sum_y[GW-1] ? GW'(-sum_y) : GW'(sum_y);
                        mag_reg[2] <= sum_z[GW-1] ? GW'(-sum_z) : GW'(sum_z);
                        neg_reg    <= {sum_z[GW-1], sum_y[GW-1], sum_x[GW-1]};
                        state_reg  <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    if (big)
                    begin
                        mag_reg[0] <= mag_reg[0] >> 1;
                        mag_reg[1] <= mag_reg[1] >> 1;
                        mag_reg[2] <= mag_reg[2] >> 1;
                    end
                    else
                    begin
                        comp_reg  <= 2'd0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    sq_reg[comp_reg] <= SQ_BITS'(mag_lo * mag_lo);
                    if (comp_reg == 2'd2)
                        state_reg <= N_SUM;
                    else
                        comp_reg <= comp_reg + 2'd1;
                end
                N_SUM:
                begin
                    n_reg    <= n_sum;
                    comp_reg <= 2'd0;
                    if (n_sum == '0)
                    begin
                        res_reg[0] <= '0;
                        res_reg[1] <= '0;
                        res_reg[2] <= '0;
                        done_reg   <= 1'b1;
                        state_reg  <= N_IDLE;
                    end
                    else
                        state_reg <= N_DINIT;
                end
                N_DINIT:
                begin
                    // quotient of sq*2^30 / n stays below 2^31
                    rem_reg   <= N_BITS'(sq_reg[comp_reg] >> 1);
                    q_reg     <= '0;
                    cnt_reg   <= 5'(DIV_STEPS - 1);
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    if (dtrial >= {1'b0, n_reg})
                    begin
                        rem_reg <= N_BITS'(dtrial - {1'b0, n_reg});
                        q_reg   <= {q_reg[Q_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= dtrial[N_BITS-1:0];
                        q_reg   <= {q_reg[Q_BITS-2:0], 1'b0};
                    end
                    if (cnt_reg == 5'd0)
                    begin
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= 5'(SQRT_STEPS - 1);
                        state_reg <= N_SQRT;
                    end
                    else
                        cnt_reg <= cnt_reg - 5'd1;
                end
                N_SQRT:
                begin
                    q_reg <= {q_reg[Q_BITS-3:0], 2'b00};
                    if (stmp >= strial)
                    begin
                        srem_reg <= stmp - strial;
                        root_reg <= {root_reg[ROOT_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= stmp;
                        root_reg <= {root_reg[ROOT_BITS-2:0], 1'b0};
                    end
                    if (cnt_reg == 5'd0)
                        state_reg <= N_STORE;
                    else
                        cnt_reg <= cnt_reg - 5'd1;
                end
                N_STORE:
                begin
                    // r = ceil-half of isqrt, sign from the gradient
                    res_reg[comp_reg] <= neg_reg[comp_reg] ? -signed'(rmag) : signed'(rmag);
                    if (comp_reg == 2'd2)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= N_DINIT;
                    end
                end
                default:
                    state_reg <= N_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign nx   = res_reg[0];
    assign ny   = res_reg[1];
    assign nz   = res_reg[2];

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ---------------------------------------------------------------------------
// tb: self-checking bench for voxel_sobel_normal
// Streams voxel volumes of several sizes, predicts each interior result
// (coordinates, surface flag, last flag, Q1.14 Sobel normal) and checks them in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import vsn_pkg::*;

    typedef struct {
        logic signed [15:0] dval;
        logic               surf;
    } voxel_t;

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               surf;
        logic [5:0]         vx;
        logic [5:0]         vy;
        logic [5:0]         vz;
        logic               last;
    } normal_t;

    logic clk;
    logic rst_n;

    vsn_voxel_if  vin();
    vsn_normal_if nout();
    vsn_cfg_if    cfg_ch();

    voxel_sobel_normal i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .voxel_in   (vin),
        .normal_out (nout),
        .cfg        (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor state
    int          vol_dist [3][64][64];
    bit          vol_surf [3][64][64];
    logic [6:0]  size_reg [3];
    int unsigned pos_x;
    int unsigned pos_y;
    int unsigned pos_z;

    voxel_t  pending_voxels[$];
    normal_t expected_normals[$];
    int      fail_count;
    int      queued;
    int      sender_idle_pct;
    int      receiver_stall_pct;
    bit      hold_sender;

    function automatic int unsigned clamp_size(logic [6:0] s);
        if (s < 3) return 3;
        if (s > 64) return 64;
        return s;
    endfunction

    // largest r in [0,16384] with (2r-1)^2 * n <= (2^15 * mag)^2
    function automatic longint unsigned unit_part(longint unsigned mag, longint unsigned n);
        logic [127:0]    tgt;
        logic [127:0]    prod;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned k;
        tgt = (128'(mag) << 15) * (128'(mag) << 15);
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            k = 2 * mid - 1;
            prod = 128'(k * k) * 128'(n);
            if (prod <= tgt)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    task automatic predict_voxel(logic signed [15:0] dval, logic surf);
        int unsigned     sx;
        int unsigned     sy;
        int unsigned     sz;
        int unsigned     cx;
        int unsigned     cy;
        int unsigned     cz;
        longint          s[3];
        longint unsigned mag[3];
        longint unsigned n;
        longint unsigned r;
        longint          wt;
        bit              last;
        normal_t         res;
        sx = clamp_size(size_reg[REG_SIZE_X]);
        sy = clamp_size(size_reg[REG_SIZE_Y]);
        sz = clamp_size(size_reg[REG_SIZE_Z]);
        vol_dist[pos_x % 3][pos_y][pos_z] = dval;
        vol_surf[pos_x % 3][pos_y][pos_z] = surf;
        last = pos_x == sx - 1 && pos_y == sy - 1 && pos_z == sz - 1;
        if (pos_x >= 2 && pos_y >= 2 && pos_z >= 2)
        begin
            cx = pos_x - 1;
            cy = pos_y - 1;
            cz = pos_z - 1;
            res.nx = 0;
            res.ny = 0;
            res.nz = 0;
            res.surf = vol_surf[cx % 3][cy][cz];
            if (res.surf)
            begin
                s = '{0, 0, 0};
                for (int a = -1; a <= 1; a++)
                    for (int b = -1; b <= 1; b++)
                    begin
                        wt = (a == 0 ? 2 : 1) * (b == 0 ? 2 : 1);
                        s[0] += wt * (vol_dist[(cx + 1) % 3][cy + a][cz + b]
                                    - vol_dist[(cx - 1) % 3][cy + a][cz + b]);
                        s[1] += wt * (vol_dist[(cx + a) % 3][cy + 1][cz + b]
                                    - vol_dist[(cx + a) % 3][cy - 1][cz + b]);
                        s[2] += wt * (vol_dist[(cx + a) % 3][cy + b][cz + 1]
                                    - vol_dist[(cx + a) % 3][cy + b][cz - 1]);
                    end
                for (int i = 0; i < 3; i++)
                    mag[i] = s[i] < 0 ? -s[i] : s[i];
                while (mag[0] >= (64'd1 << 21) || mag[1] >= (64'd1 << 21)
                       || mag[2] >= (64'd1 << 21))
                    for (int i = 0; i < 3; i++)
                        mag[i] >>= 1;
                n = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
                if (n != 0)
                begin
                    r = unit_part(mag[0], n);
                    res.nx = s[0] < 0 ? -r[15:0] : r[15:0];
                    r = unit_part(mag[1], n);
                    res.ny = s[1] < 0 ? -r[15:0] : r[15:0];
                    r = unit_part(mag[2], n);
                    res.nz = s[2] < 0 ? -r[15:0] : r[15:0];
                end
            end
            res.vx = cx[5:0];
            res.vy = cy[5:0];
            res.vz = cz[5:0];
            res.last = last;
            expected_normals.push_back(res);
        end
        if (last)
        begin
            pos_x = 0;
            pos_y = 0;
            pos_z = 0;
        end
        else if (pos_z + 1 < sz)
            pos_z++;
        else
        begin
            pos_z = 0;
            if (pos_y + 1 < sy)
                pos_y++;
            else
            begin
                pos_y = 0;
                pos_x++;
            end
        end
    endtask

    task automatic report(string field, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        fail_count++;
    endtask

    // voxel driver
    always @(posedge clk or negedge rst_n)
    begin
        voxel_t v;
        if (!rst_n)
        begin
            vin.valid        <= 1'b0;
            vin.dist_value   <= '0;
            vin.surface_flag <= 1'b0;
        end
        else
        begin
            if (vin.valid && vin.ready)
                predict_voxel(vin.dist_value, vin.surface_flag);
            if (!vin.valid || vin.ready)
            begin
                if (pending_voxels.size() > 0 && !hold_sender
                    && $urandom_range(99) >= sender_idle_pct)
                begin
                    v = pending_voxels.pop_front();
                    vin.valid        <= 1'b1;
                    vin.dist_value   <= v.dval;
                    vin.surface_flag <= v.surf;
                end
                else
                    vin.valid <= 1'b0;
            end
        end
    end

    // normal monitor
    always @(posedge clk or negedge rst_n)
    begin
        normal_t want;
        if (!rst_n)
            nout.ready <= 1'b0;
        else
        begin
            if (nout.valid && nout.ready)
            begin
                if (expected_normals.size() == 0)
                begin
                    $display("unexpected normal item at %0t", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = expected_normals.pop_front();
                    if (nout.normal_x !== want.nx) report("normal_x", nout.normal_x, want.nx);
                    if (nout.normal_y !== want.ny) report("normal_y", nout.normal_y, want.ny);
                    if (nout.normal_z !== want.nz) report("normal_z", nout.normal_z, want.nz);
                    if (nout.is_surface !== want.surf)
                        report("is_surface", nout.is_surface, want.surf);
                    if (nout.voxel_x !== want.vx) report("voxel_x", nout.voxel_x, want.vx);
                    if (nout.voxel_y !== want.vy) report("voxel_y", nout.voxel_y, want.vy);
                    if (nout.voxel_z !== want.vz) report("voxel_z", nout.voxel_z, want.vz);
                    if (nout.last_of_volume !== want.last)
                        report("last_of_volume", nout.last_of_volume, want.last);
                end
            end
            nout.ready <= $urandom_range(99) >= receiver_stall_pct;
        end
    end

    task automatic wait_drained();
        while (pending_voxels.size() > 0 || vin.valid || expected_normals.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_size(cfg_reg_t idx, logic [6:0] value);
        wait_drained();
        // voxels without a result may still be in flight
        repeat (300) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        size_reg[idx] = value;
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
    endtask

    task automatic queue_voxel(int dval, bit surf);
        voxel_t v;
        v.dval = dval[15:0];
        v.surf = surf;
        @(negedge clk);
        pending_voxels.push_back(v);
        queued++;
    endtask

    // count items; kind 0 random noise, else smooth ramp with random slopes
    task automatic queue_volume(int count, int kind);
        int unsigned sy;
        int unsigned sz;
        int          gx;
        int          gy;
        int          gz;
        int          base;
        int          surf_pct;
        sy = clamp_size(size_reg[REG_SIZE_Y]);
        sz = clamp_size(size_reg[REG_SIZE_Z]);
        gx = $urandom_range(4000) - 2000;
        gy = $urandom_range(4000) - 2000;
        gz = $urandom_range(4000) - 2000;
        base = $urandom_range(65535) - 32768;
        surf_pct = $urandom_range(100);
        for (int i = 0; i < count; i++)
        begin
            if (kind == 0)
                queue_voxel($urandom_range(65535), $urandom_range(99) < surf_pct);
            else
                queue_voxel(base + gx * (i / (sy * sz)) + gy * ((i / sz) % sy)
                            + gz * (i % sz) + $urandom_range(64) - 32,
                            $urandom_range(99) < surf_pct);
        end
    endtask

    function automatic int volume_items();
        return clamp_size(size_reg[REG_SIZE_X]) * clamp_size(size_reg[REG_SIZE_Y])
             * clamp_size(size_reg[REG_SIZE_Z]);
    endfunction

    initial
    begin
        logic [6:0] pick;
        int         n;
        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.addr        = '0;
        cfg_ch.data        = '0;
        vin.valid          = 1'b0;
        vin.dist_value     = '0;
        vin.surface_flag   = 1'b0;
        nout.ready         = 1'b0;
        fail_count         = 0;
        queued             = 0;
        hold_sender        = 1'b0;
        sender_idle_pct    = 22;
        receiver_stall_pct = 74;
        size_reg = '{7'd64, 7'd64, 7'd64};
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // smallest volume, zero gradient at a surface centre
        write_size(REG_SIZE_X, 7'd3);
        write_size(REG_SIZE_Y, 7'd0);
        write_size(REG_SIZE_Z, 7'd2);
        for (int i = 0; i < 27; i++)
            queue_voxel(0, i == 13);
        // full-scale step along x with extreme values
        for (int i = 0; i < 27; i++)
            queue_voxel(i < 9 ? -32768 : (i >= 18 ? 32767 : 0), 1'b1);
        // non-surface centre with steep gradient
        for (int i = 0; i < 27; i++)
            queue_voxel(i % 2 ? 32767 : -32768, i != 13);

        // oversize clamps to the maximum extent along z
        write_size(REG_SIZE_Z, 7'd127);
        write_size(REG_SIZE_Y, 7'd1);
        queue_volume(volume_items(), 1);

        while (queued < 1850)
        begin
            if (queued > 1250)
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            else if (queued > 650)
            begin
                sender_idle_pct    = 74;
                receiver_stall_pct = 22;
            end
            for (int r = 0; r < 3; r++)
            begin
                if ($urandom_range(2) == 0)
                begin
                    case ($urandom_range(9))
                        0: pick = $urandom_range(2);
                        1: pick = $urandom_range(127, 64);
                        default: pick = $urandom_range(6, 3);
                    endcase
                    write_size(cfg_reg_t'(r), pick);
                end
            end
            // keep volumes small when an axis got large
            if (volume_items() > 600)
                write_size(REG_SIZE_X, 7'd3);
            if (volume_items() > 600)
                write_size(REG_SIZE_Y, 7'd3);
            n = $urandom_range(2, 1);
            for (int v = 0; v < n; v++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    // hold the sender mid-volume until all results are back
                    queue_volume(volume_items() / 2, 1);
                    @(negedge clk);
                    hold_sender = 1'b1;
                    while (vin.valid || expected_normals.size() > 0)
                        @(posedge clk);
                    @(negedge clk);
                    hold_sender = 1'b0;
                    queue_volume(volume_items() - volume_items() / 2, 1);
                end
                else
                    queue_volume(volume_items(), $urandom_range(4) == 0 ? 0 : 1);
            end
            // occasionally abandon a volume partway; next write restarts it
            if ($urandom_range(5) == 0)
                queue_volume($urandom_range(volume_items() - 1, 1), 1);
        end

        wait_drained();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("voxel_sobel_normal verification clean");
        else
            $display("voxel_sobel_normal verification failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("voxel_sobel_normal verification failed");
        $finish;
    end

endmodule
